// ===== sv/texture_wrap_address_macros.svh =====
// Assertion macros shared by the texture wrap address checks.
// Clocked on clock, disabled while reset is high; no other dependencies.
`ifndef TEXTURE_WRAP_ADDRESS_MACROS_SVH
`define TEXTURE_WRAP_ADDRESS_MACROS_SVH

// Same-cycle implication.
`define TWA_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TWA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/twa_pkg.sv =====
// Shared types, constants and helpers for the texture wrap address block.
// No dependencies; imported by every module of the block.
package twa_pkg;

   localparam int MAX_DIM         = 4096;
   localparam int BYTES_PER_TEXEL = 4;

   localparam int COORD_W  = 32;
   localparam int SIZE_W   = 13;   // holds 1..MAX_DIM
   localparam int MOD_W    = 14;   // holds up to 2*MAX_DIM
   localparam int WRAP_W   = 12;
   localparam int INDEX_W  = 24;
   localparam int OFFSET_W = 26;
   localparam int MODE_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam int REQ_TDATA_W = 2 * COORD_W;
   localparam int RSP_FIELD_W = 2 * WRAP_W + INDEX_W + OFFSET_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   // Remainder is formed four quotient bits per stage.
   localparam int BITS_PER_STAGE = 4;
   localparam int DIV_STAGES     = COORD_W / BITS_PER_STAGE;
   // prep + divide stages + sign fix + final select
   localparam int AXIS_STAGES    = DIV_STAGES + 3;

   typedef enum logic [MODE_W-1:0] {
      WRAP_CLAMP  = 2'd0,
      WRAP_REPEAT = 2'd1,
      WRAP_MIRROR = 2'd2
   } wrap_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WRAP_MODE_S = 2'd0,
      CSR_WRAP_MODE_T = 2'd1,
      CSR_TEX_WIDTH   = 2'd2,
      CSR_TEX_HEIGHT  = 2'd3
   } csr_index_type;

   // Per-axis settings seen by a wrap unit.
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [SIZE_W-1:0] size;
      logic [MOD_W-1:0]  modulus;
   } axis_cfg_type;

   // Data carried down the wrap pipeline.
   typedef struct packed {
      logic               neg;
      logic [COORD_W-1:0] mag;
      logic [SIZE_W-1:0]  rem;
      logic [WRAP_W-1:0]  clamp;
   } axis_pl_type;

   // Size register to the size in use: zero reads as one, large values saturate.
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw);
      logic [SIZE_W-1:0] v;
      v = raw;
      if (v == '0) begin
         v = SIZE_W'(1);
      end else if (v > SIZE_W'(MAX_DIM)) begin
         v = SIZE_W'(MAX_DIM);
      end
      return v;
   endfunction

   function automatic axis_cfg_type make_axis_cfg(input logic [MODE_W-1:0] mode,
                                                  input logic [SIZE_W-1:0] raw);
      axis_cfg_type c;
      c.mode = mode;
      c.size = eff_size(raw);
      if (mode == WRAP_MIRROR) begin
         c.modulus = {c.size, 1'b0};
      end else begin
         c.modulus = {1'b0, c.size};
      end
      return c;
   endfunction

endpackage

// ===== sv/texture_wrap_address.sv =====
// Texture coordinate wrap and texel addressing, top level.
// Uses twa_pkg, twa_axis_wrap (one per axis) and twa_addr.
//
// Request beats carry a signed s/t coordinate pair; each response beat carries
// the wrapped pair, the row-major texel index and the RGBA8 byte offset.
// Exactly one response per request, in order.
// Registers are written through csr_we/csr_index/csr_wdata; the user must
// write them only while no request is in flight; the block does not enforce it.
// Wrap modes: clamp, repeat, mirrored repeat. A request beat passes each axis
// unit, where the 32-bit remainder takes four bits per stage, and then the row
// multiply and add stages before its response is valid.
// Throughput: one beat per cycle while rsp_tready is high.
// Reset (synchronous, active high) empties the pipeline and sets both wrap
// modes to repeat and both sizes to 1.
// A stalled response holds its beat; req_tready stays high until every stage
// holds a beat, so up to 13 requests are taken under a stall.
module texture_wrap_address (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [twa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [twa_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [twa_pkg::REQ_TDATA_W-1:0]   req_tdata,  // coord_s, coord_t
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // wrapped_s, wrapped_t, texel_index, byte_offset, zero pad
   output logic [twa_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import twa_pkg::*;

   logic [MODE_W-1:0]   mode_s_ff;
   logic [MODE_W-1:0]   mode_t_ff;
   logic [SIZE_W-1:0]   width_ff;
   logic [SIZE_W-1:0]   height_ff;
   axis_cfg_type        cfg_s;
   axis_cfg_type        cfg_t;

   logic                rdy_s;
   logic                rdy_t;
   logic                vld_s;
   logic                vld_t;
   logic [WRAP_W-1:0]   wrap_s;
   logic [WRAP_W-1:0]   wrap_t;
   logic                addr_rdy;
   logic [WRAP_W-1:0]   out_s;
   logic [WRAP_W-1:0]   out_t;
   logic [INDEX_W-1:0]  out_index;
   logic [OFFSET_W-1:0] out_offset;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_s_ff <= WRAP_REPEAT;
         mode_t_ff <= WRAP_REPEAT;
         width_ff  <= SIZE_W'(1);
         height_ff <= SIZE_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_WRAP_MODE_S: mode_s_ff <= csr_wdata[MODE_W-1:0];
            CSR_WRAP_MODE_T: mode_t_ff <= csr_wdata[MODE_W-1:0];
            CSR_TEX_WIDTH:   width_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_TEX_HEIGHT:  height_ff <= csr_wdata[SIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg_s = make_axis_cfg(mode_s_ff, width_ff);
   assign cfg_t = make_axis_cfg(mode_t_ff, height_ff);

   // Both axis units see identical valid/ready traffic and stay in lockstep.
   assign req_tready = rdy_s && rdy_t;

   twa_axis_wrap u_axis_s (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_s),
      .in_valid    (req_tvalid),
      .in_ready    (rdy_s),
      .in_coord    (req_tdata[COORD_W-1:0]),
      .out_valid   (vld_s),
      .out_ready   (addr_rdy && vld_t),
      .out_wrapped (wrap_s)
   );

   twa_axis_wrap u_axis_t (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_t),
      .in_valid    (req_tvalid),
      .in_ready    (rdy_t),
      .in_coord    (req_tdata[2*COORD_W-1:COORD_W]),
      .out_valid   (vld_t),
      .out_ready   (addr_rdy && vld_s),
      .out_wrapped (wrap_t)
   );

   twa_addr u_addr (
      .clock      (clock),
      .reset      (reset),
      .width      (cfg_s.size),
      .in_valid   (vld_s && vld_t),
      .in_ready   (addr_rdy),
      .in_s       (wrap_s),
      .in_t       (wrap_t),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_s      (out_s),
      .out_t      (out_t),
      .out_index  (out_index),
      .out_offset (out_offset)
   );

   assign rsp_tdata = {{(RSP_TDATA_W-RSP_FIELD_W){1'b0}},
                       out_offset, out_index, out_t, out_s};

endmodule

// ===== sv/twa_axis_wrap.sv =====
// One axis of coordinate wrapping: clamp, repeat or mirrored repeat.
// Restoring remainder pipeline over DIV_STAGES stages; uses twa_pkg.
module twa_axis_wrap (
   input  logic                         clock,
   input  logic                         reset,
   input  twa_pkg::axis_cfg_type        cfg,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [twa_pkg::COORD_W-1:0]  in_coord,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [twa_pkg::WRAP_W-1:0]   out_wrapped
);
   import twa_pkg::*;

   localparam int FIX  = DIV_STAGES + 1;
   localparam int LAST = AXIS_STAGES - 1;

   logic [AXIS_STAGES-1:0] vld_ff;
   logic [AXIS_STAGES-1:0] vld_in;
   logic [AXIS_STAGES:0]   rdy;
   axis_pl_type            pl_ff [0:FIX];
   axis_pl_type            pl_in [0:FIX];
   logic [WRAP_W-1:0]      wrapped_ff;
   logic [WRAP_W-1:0]      wrapped_in;

   function automatic axis_pl_type div_step(input axis_pl_type p,
                                            input logic [MOD_W-1:0] m);
      axis_pl_type        o;
      logic [MOD_W-1:0]   r;
      logic [COORD_W-1:0] q;
      o = p;
      r = {1'b0, p.rem};
      q = p.mag;
      for (int i = 0; i < BITS_PER_STAGE; i++) begin
         r = {r[MOD_W-2:0], q[COORD_W-1]};
         q = {q[COORD_W-2:0], 1'b0};
         if (r >= m) begin
            r = r - m;
         end
      end
      o.rem = r[SIZE_W-1:0];
      o.mag = q;
      return o;
   endfunction

   // Ready runs back from the output; a bubble lets the stages behind it move.
   always_comb begin
      rdy[AXIS_STAGES] = out_ready;
      for (int k = AXIS_STAGES - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in[0] = in_valid;
      for (int k = 1; k < AXIS_STAGES; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   assign in_ready = rdy[0];

   always_comb begin
      // Stage 0: sign, magnitude and the clamp answer.
      pl_in[0].neg = in_coord[COORD_W-1];
      pl_in[0].mag = in_coord[COORD_W-1] ? (~in_coord + COORD_W'(1)) : in_coord;
      pl_in[0].rem = '0;
      if (in_coord[COORD_W-1]) begin
         pl_in[0].clamp = '0;
      end else if (in_coord >= {{(COORD_W-SIZE_W){1'b0}}, cfg.size}) begin
         pl_in[0].clamp = WRAP_W'(cfg.size - SIZE_W'(1));
      end else begin
         pl_in[0].clamp = in_coord[WRAP_W-1:0];
      end

      for (int j = 1; j <= DIV_STAGES; j++) begin
         pl_in[j] = div_step(pl_ff[j-1], cfg.modulus);
      end

      // Negative input: floor remainder is modulus minus the magnitude remainder.
      pl_in[FIX] = pl_ff[DIV_STAGES];
      if (pl_ff[DIV_STAGES].neg && (pl_ff[DIV_STAGES].rem != '0)) begin
         pl_in[FIX].rem = SIZE_W'(cfg.modulus - {1'b0, pl_ff[DIV_STAGES].rem});
      end
   end

   always_comb begin
      case (cfg.mode)
         WRAP_REPEAT: begin
            wrapped_in = pl_ff[FIX].rem[WRAP_W-1:0];
         end
         WRAP_MIRROR: begin
            if (pl_ff[FIX].rem >= cfg.size) begin
               wrapped_in = WRAP_W'(cfg.modulus - MOD_W'(1) - {1'b0, pl_ff[FIX].rem});
            end else begin
               wrapped_in = pl_ff[FIX].rem[WRAP_W-1:0];
            end
         end
         default: begin
            wrapped_in = pl_ff[FIX].clamp;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < AXIS_STAGES; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= FIX; k++) begin
         if (rdy[k]) begin
            pl_ff[k] <= pl_in[k];
         end
      end
      if (rdy[LAST]) begin
         wrapped_ff <= wrapped_in;
      end
   end

   assign out_valid   = vld_ff[LAST];
   assign out_wrapped = wrapped_ff;

endmodule

// ===== sv/twa_addr.sv =====
// Texel index and byte offset from a wrapped coordinate pair.
// Two stages: row multiply, then add and scale; uses twa_pkg.
module twa_addr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [twa_pkg::SIZE_W-1:0]    width,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [twa_pkg::WRAP_W-1:0]    in_s,
   input  logic [twa_pkg::WRAP_W-1:0]    in_t,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [twa_pkg::WRAP_W-1:0]    out_s,
   output logic [twa_pkg::WRAP_W-1:0]    out_t,
   output logic [twa_pkg::INDEX_W-1:0]   out_index,
   output logic [twa_pkg::OFFSET_W-1:0]  out_offset
);
   import twa_pkg::*;

   logic                 vld_a_ff;
   logic                 vld_b_ff;
   logic                 rdy_a;
   logic                 rdy_b;
   logic [WRAP_W-1:0]    s_a_ff;
   logic [WRAP_W-1:0]    t_a_ff;
   logic [INDEX_W-1:0]   row_a_ff;
   logic [INDEX_W-1:0]   row_a_in;
   logic [WRAP_W-1:0]    s_b_ff;
   logic [WRAP_W-1:0]    t_b_ff;
   logic [INDEX_W-1:0]   idx_b_ff;
   logic [INDEX_W-1:0]   idx_b_in;
   logic [OFFSET_W-1:0]  off_b_ff;
   logic [OFFSET_W-1:0]  off_b_in;

   assign rdy_b    = !vld_b_ff || out_ready;
   assign rdy_a    = !vld_a_ff || rdy_b;
   assign in_ready = rdy_a;

   assign row_a_in = INDEX_W'(in_t * width);
   assign idx_b_in = INDEX_W'(row_a_ff + {{(INDEX_W-WRAP_W){1'b0}}, s_a_ff});
   assign off_b_in = OFFSET_W'({{(OFFSET_W-INDEX_W){1'b0}}, idx_b_in}
                               * OFFSET_W'(BYTES_PER_TEXEL));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else begin
         if (rdy_a) begin
            vld_a_ff <= in_valid;
         end
         if (rdy_b) begin
            vld_b_ff <= vld_a_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a) begin
         s_a_ff   <= in_s;
         t_a_ff   <= in_t;
         row_a_ff <= row_a_in;
      end
      if (rdy_b) begin
         s_b_ff   <= s_a_ff;
         t_b_ff   <= t_a_ff;
         idx_b_ff <= idx_b_in;
         off_b_ff <= off_b_in;
      end
   end

   assign out_valid  = vld_b_ff;
   assign out_s      = s_b_ff;
   assign out_t      = t_b_ff;
   assign out_index  = idx_b_ff;
   assign out_offset = off_b_ff;

endmodule

// ===== sv/twa_checker.sv =====
// Port-level checks for texture_wrap_address, bound to the top level.
// Uses twa_pkg and the macros in texture_wrap_address_macros.svh.
`include "texture_wrap_address_macros.svh"

module twa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [twa_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import twa_pkg::*;

   logic [OFFSET_W-1:0] rsp_offset;
   logic [INDEX_W-1:0]  rsp_index;

   assign rsp_offset = rsp_tdata[RSP_FIELD_W-1:2*WRAP_W+INDEX_W];
   assign rsp_index  = rsp_tdata[2*WRAP_W+INDEX_W-1:2*WRAP_W];

   // A stalled response beat must not change.
   `TWA_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "twa: stalled response beat changed")

   // Reset leaves the pipeline empty.
   `TWA_ASSERT_IMPL(a_rsp_empty_after_reset, $past(reset), !rsp_tvalid, "twa: response valid straight after reset")

   // With no beat waiting at the output nothing can hold up a request.
   `TWA_ASSERT_IMPL(a_req_ready_when_drained, !rsp_tvalid, req_tready, "twa: request refused with empty output")

   // Index and offset must agree on every response beat.
   `TWA_ASSERT_IMPL(a_offset_matches_index, rsp_tvalid, rsp_offset == {rsp_index, 2'b00}, "twa: offset does not match index")

endmodule

bind texture_wrap_address twa_checker u_twa_checker (.*);
